[hw/rtl/semaphore_engine_fifo_pi_unit_assert.svh]
// ----------------------------------------------------------------------------
// semaphore_engine_fifo_pi_unit_assert.svh
// Assertion macros for the checker file of the semaphore unit.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_ENGINE_FIFO_PI_UNIT_ASSERT_SVH
`define SEMAPHORE_ENGINE_FIFO_PI_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SEFP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("semaphore unit assertion failed");

// next-cycle implication, disabled in reset
`define SEFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("semaphore unit assertion failed");

`endif

[hw/rtl/semfp_pkg.sv]
// ----------------------------------------------------------------------------
// semfp_pkg
// Types, constants and helpers of the semaphore unit.
// ----------------------------------------------------------------------------
package semfp_pkg;

	localparam int NUM_SEMS    = 64;
	localparam int NUM_WAITERS = 64;
	localparam int NUM_TASKS   = 256;
	localparam int SEM_W       = 6;
	localparam int WT_W        = 6;
	localparam int PTR_W       = WT_W + 1;
	localparam int MAX_RES     = 4;
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_AW    = 3;

	localparam logic [PTR_W-1:0] PTR_NIL   = {1'b1, {WT_W{1'b0}}};
	localparam logic [7:0]       NO_PRIO   = 8'hFF;
	localparam logic [15:0]      REFS_MAX  = 16'hFFFF;
	localparam logic signed [31:0] COUNT_MAX = 32'sh7FFF_FFFF;

	// opcodes
	localparam logic [2:0] OP_CREATE   = 3'd0;
	localparam logic [2:0] OP_WAIT     = 3'd1;
	localparam logic [2:0] OP_TRYWAIT  = 3'd2;
	localparam logic [2:0] OP_POST     = 3'd3;
	localparam logic [2:0] OP_RETIRE   = 3'd4;
	localparam logic [2:0] OP_GETVALUE = 3'd5;
	localparam logic [2:0] OP_CLOSE    = 3'd6;
	localparam logic [2:0] OP_OPEN     = 3'd7;

	// result kinds
	localparam logic [1:0] K_REPLY  = 2'd0;
	localparam logic [1:0] K_GRANT  = 2'd1;
	localparam logic [1:0] K_DONATE = 2'd2;
	localparam logic [1:0] K_CLEAR  = 2'd3;

	// reply status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_BLOCK    = 3'd3;
	localparam logic [2:0] ST_NOSPACE  = 3'd4;
	localparam logic [2:0] ST_CANCEL   = 3'd5;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [SEM_W-1:0] sem_slot;
		logic [WT_W-1:0]  waiter_slot;
		logic [7:0]       task_id;
		logic [7:0]       task_prio;
		logic [30:0]      init_value;
		logic             rt_mode;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         status;
		logic [5:0]         slot_out;
		logic [7:0]         task_out;
		logic [7:0]         prio_out;
		logic signed [31:0] count_out;
		logic               last;
	} res_t;

	typedef struct packed {
		logic signed [31:0] count;
		logic               rt;
		logic [15:0]        refs;
		logic               owner_v;
		logic [7:0]         owner_task;
		logic [PTR_W-1:0]   head;
		logic [PTR_W-1:0]   tail;
	} sem_ent_t;

	typedef struct packed {
		logic             granted;
		logic [7:0]       task_id;
		logic [7:0]       prio;
		logic [PTR_W-1:0] next;
		logic [SEM_W-1:0] sem;
	} wt_ent_t;

	typedef struct packed {
		logic             we;
		logic [SEM_W-1:0] waddr;
		sem_ent_t         wdata;
		logic [SEM_W-1:0] raddr;
	} smem_req_t;

	typedef struct packed {
		logic            we;
		logic [WT_W-1:0] waddr;
		wt_ent_t         wdata;
		logic [WT_W-1:0] raddr;
	} wmem_req_t;

	function automatic res_t mk_reply(logic [2:0] st, logic [5:0] slot,
			logic signed [31:0] cnt);
		res_t r;
		r.kind      = K_REPLY;
		r.status    = st;
		r.slot_out  = slot;
		r.task_out  = 8'd0;
		r.prio_out  = 8'd0;
		r.count_out = cnt;
		r.last      = 1'b1;
		return r;
	endfunction

	function automatic res_t mk_event(logic [1:0] k, logic [5:0] slot,
			logic [7:0] tk, logic [7:0] pr);
		res_t r;
		r.kind      = k;
		r.status    = ST_OK;
		r.slot_out  = slot;
		r.task_out  = tk;
		r.prio_out  = pr;
		r.count_out = 32'sd0;
		r.last      = 1'b0;
		return r;
	endfunction

endpackage

[hw/rtl/semfp_ram.sv]
// ----------------------------------------------------------------------------
// semfp_ram
// Generic RAM, one write and one read port, registered read, write-first.
// ----------------------------------------------------------------------------
module semfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		// same-edge write to the read address returns the new word
		if (we && (waddr == raddr))
			rdata <= wdata;
		else
			rdata <= mem[raddr];
	end

endmodule

[hw/rtl/semfp_ofifo.sv]
// ----------------------------------------------------------------------------
// semfp_ofifo
// Result queue between the sequencer and the output stream.
// ----------------------------------------------------------------------------
module semfp_ofifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  semfp_pkg::res_t   push_item,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output semfp_pkg::res_t   out_item
);

	semfp_pkg::res_t                      buf_q [semfp_pkg::OFIFO_DEPTH];
	logic [semfp_pkg::OFIFO_AW-1:0]       wr_q;
	logic [semfp_pkg::OFIFO_AW-1:0]       rd_q;
	logic [semfp_pkg::OFIFO_AW:0]         cnt_q;
	logic                                 pop;

	assign out_valid = (cnt_q != '0);
	assign out_item  = buf_q[rd_q];
	assign pop       = out_valid && out_ready;
	// room for a whole command's worth of results
	assign room      = (cnt_q <= (semfp_pkg::OFIFO_AW+1)'(semfp_pkg::OFIFO_DEPTH
		- semfp_pkg::MAX_RES));

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hw/rtl/semfp_ctrl.sv]
// ----------------------------------------------------------------------------
// semfp_ctrl
// Command sequencer: read-modify-write over the semaphore and waiter RAMs.
// ----------------------------------------------------------------------------
module semfp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  semfp_pkg::cmd_t       cmd,
	input  logic                  room,
	output logic                  push,
	output semfp_pkg::res_t       push_item,
	output semfp_pkg::smem_req_t  sreq,
	input  semfp_pkg::sem_ent_t   srdata,
	output semfp_pkg::wmem_req_t  wreq,
	input  semfp_pkg::wt_ent_t    wrdata
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_RD_WAIT, S_RD_LATCH, S_CR_SCAN, S_EXEC, S_WT_SCAN,
		S_WAIT_TAIL, S_POST_H, S_POST_G, S_RT_W, S_RT_S, S_UNL_RD, S_UNL_CHK,
		S_RT_FREE, S_PI_START, S_PI_RD, S_PI_CHK, S_DESTROY, S_FIN
	} state_t;

	state_t                              state_q, ret_q;
	logic                                rd_sem_q, rd_wt_q;
	logic [semfp_pkg::SEM_W-1:0]         sra_q;
	logic [semfp_pkg::WT_W-1:0]          wra_q;
	semfp_pkg::cmd_t                     cmd_q;
	semfp_pkg::sem_ent_t                 se_q;
	semfp_pkg::wt_ent_t                  we_q, pe_q;
	semfp_pkg::res_t                     rep_q, push_item_q;
	logic                                push_q;
	logic [semfp_pkg::SEM_W-1:0]         tgt_q;
	logic [semfp_pkg::WT_W-1:0]          i_q, new_q, h_q;
	logic [semfp_pkg::PTR_W-1:0]         cur_q, prev_q;
	logic [semfp_pkg::PTR_W-1:0]         steps_q;
	logic [7:0]                          best_q;
	logic                                gr_q;
	logic [semfp_pkg::NUM_SEMS-1:0]      sem_act_q;
	logic [semfp_pkg::NUM_WAITERS-1:0]   wt_act_q;
	logic                                swe_q, wwe_q;
	logic [semfp_pkg::SEM_W-1:0]         swa_q;
	logic [semfp_pkg::WT_W-1:0]          wwa_q;
	semfp_pkg::sem_ent_t                 swd_q;
	semfp_pkg::wt_ent_t                  wwd_q;
	logic                                owner_on;

	assign in_ready  = (state_q == S_IDLE) && !push_q && room;
	assign push      = push_q;
	assign push_item = push_item_q;
	assign sreq      = '{we: swe_q, waddr: swa_q, wdata: swd_q, raddr: sra_q};
	assign wreq      = '{we: wwe_q, waddr: wwa_q, wdata: wwd_q, raddr: wra_q};
	assign owner_on  = se_q.rt && se_q.owner_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			rd_sem_q  <= 1'b0;
			rd_wt_q   <= 1'b0;
			push_q    <= 1'b0;
			swe_q     <= 1'b0;
			wwe_q     <= 1'b0;
			sem_act_q <= '0;
			wt_act_q  <= '0;
		end else begin
			push_q <= 1'b0;
			swe_q  <= 1'b0;
			wwe_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q   <= cmd;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					rep_q <= semfp_pkg::mk_reply(semfp_pkg::ST_OK, 6'd0, 32'sd0);
					if (9'(cmd_q.task_id) >= 9'(semfp_pkg::NUM_TASKS)) begin
						push_q      <= 1'b1;
						push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_NOTFOUND,
							6'd0, 32'sd0);
						state_q     <= S_IDLE;
					end else begin
						case (cmd_q.opcode)
							semfp_pkg::OP_CREATE: begin
								i_q     <= '0;
								state_q <= S_CR_SCAN;
							end
							semfp_pkg::OP_RETIRE: begin
								if (!wt_act_q[cmd_q.waiter_slot]) begin
									push_q      <= 1'b1;
									push_item_q <= semfp_pkg::mk_reply(
										semfp_pkg::ST_NOTFOUND, 6'd0, 32'sd0);
									state_q     <= S_IDLE;
								end else begin
									wra_q    <= cmd_q.waiter_slot;
									rd_sem_q <= 1'b0;
									rd_wt_q  <= 1'b1;
									ret_q    <= S_RT_W;
									state_q  <= S_RD_WAIT;
								end
							end
							default: begin
								tgt_q    <= cmd_q.sem_slot;
								sra_q    <= cmd_q.sem_slot;
								rd_sem_q <= 1'b1;
								rd_wt_q  <= 1'b0;
								ret_q    <= S_EXEC;
								state_q  <= S_RD_WAIT;
							end
						endcase
					end
				end
				S_RD_WAIT: state_q <= S_RD_LATCH;
				S_RD_LATCH: begin
					if (rd_sem_q)
						se_q <= srdata;
					if (rd_wt_q)
						we_q <= wrdata;
					state_q <= ret_q;
				end
				S_CR_SCAN: begin
					if (!sem_act_q[i_q]) begin
						sem_act_q[i_q] <= 1'b1;
						swe_q <= 1'b1;
						swa_q <= i_q;
						swd_q <= '{count: {1'b0, cmd_q.init_value}, rt: cmd_q.rt_mode,
							refs: 16'd1, owner_v: 1'b0, owner_task: 8'd0,
							head: semfp_pkg::PTR_NIL, tail: semfp_pkg::PTR_NIL};
						push_q      <= 1'b1;
						push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_OK,
							6'(i_q), 32'sd0);
						state_q     <= S_IDLE;
					end else if (i_q == semfp_pkg::SEM_W'(semfp_pkg::NUM_SEMS - 1)) begin
						push_q      <= 1'b1;
						push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_NOSPACE,
							6'd0, 32'sd0);
						state_q     <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_EXEC: begin
					if (cmd_q.opcode == semfp_pkg::OP_OPEN) begin
						push_q  <= 1'b1;
						state_q <= S_IDLE;
						if (!sem_act_q[tgt_q])
							push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_NOTFOUND,
								6'd0, 32'sd0);
						else if (se_q.refs == semfp_pkg::REFS_MAX)
							push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_NOSPACE,
								6'd0, 32'sd0);
						else begin
							swe_q       <= 1'b1;
							swa_q       <= tgt_q;
							swd_q       <= se_q;
							swd_q.refs  <= se_q.refs + 16'd1;
							push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_OK,
								6'd0, 32'sd0);
						end
					end else if (!sem_act_q[tgt_q] || (se_q.refs == 16'd0)) begin
						push_q      <= 1'b1;
						push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_NOTFOUND,
							6'd0, 32'sd0);
						state_q     <= S_IDLE;
					end else begin
						case (cmd_q.opcode)
							semfp_pkg::OP_GETVALUE: begin
								push_q      <= 1'b1;
								push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_OK,
									6'd0, se_q.count);
								state_q     <= S_IDLE;
							end
							semfp_pkg::OP_CLOSE: begin
								se_q.refs <= se_q.refs - 16'd1;
								state_q   <= S_DESTROY;
							end
							semfp_pkg::OP_WAIT, semfp_pkg::OP_TRYWAIT: begin
								if (se_q.count > 32'sd0) begin
									if (owner_on && (se_q.owner_task != cmd_q.task_id)) begin
										push_q      <= 1'b1;
										push_item_q <= semfp_pkg::mk_event(
											semfp_pkg::K_CLEAR, 6'd0, se_q.owner_task, 8'd0);
									end
									se_q.count <= se_q.count - 32'sd1;
									if (se_q.rt) begin
										se_q.owner_v    <= 1'b1;
										se_q.owner_task <= cmd_q.task_id;
									end
									state_q <= S_PI_START;
								end else if (cmd_q.opcode == semfp_pkg::OP_TRYWAIT) begin
									push_q      <= 1'b1;
									push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_BLOCK,
										6'd0, 32'sd0);
									state_q     <= S_IDLE;
								end else begin
									i_q     <= '0;
									state_q <= S_WT_SCAN;
								end
							end
							semfp_pkg::OP_POST: begin
								if (!se_q.head[semfp_pkg::WT_W]) begin
									h_q      <= se_q.head[semfp_pkg::WT_W-1:0];
									wra_q    <= se_q.head[semfp_pkg::WT_W-1:0];
									rd_sem_q <= 1'b0;
									rd_wt_q  <= 1'b1;
									ret_q    <= S_POST_H;
									state_q  <= S_RD_WAIT;
								end else begin
									se_q.head <= semfp_pkg::PTR_NIL;
									se_q.tail <= semfp_pkg::PTR_NIL;
									if (owner_on) begin
										push_q      <= 1'b1;
										push_item_q <= semfp_pkg::mk_event(
											semfp_pkg::K_CLEAR, 6'd0, se_q.owner_task, 8'd0);
									end
									se_q.owner_v    <= 1'b0;
									se_q.owner_task <= 8'd0;
									if (se_q.count < semfp_pkg::COUNT_MAX)
										se_q.count <= se_q.count + 32'sd1;
									state_q <= S_DESTROY;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_WT_SCAN: begin
					if (!wt_act_q[i_q]) begin
						wt_act_q[i_q] <= 1'b1;
						new_q <= i_q;
						wwe_q <= 1'b1;
						wwa_q <= i_q;
						wwd_q <= '{granted: 1'b0, task_id: cmd_q.task_id,
							prio: cmd_q.task_prio, next: semfp_pkg::PTR_NIL, sem: tgt_q};
						rep_q <= semfp_pkg::mk_reply(semfp_pkg::ST_QUEUED, 6'(i_q), 32'sd0);
						se_q.tail <= {1'b0, i_q};
						if (se_q.head[semfp_pkg::WT_W] || se_q.tail[semfp_pkg::WT_W]) begin
							se_q.head <= {1'b0, i_q};
							state_q   <= S_PI_START;
						end else begin
							wra_q    <= se_q.tail[semfp_pkg::WT_W-1:0];
							rd_sem_q <= 1'b0;
							rd_wt_q  <= 1'b1;
							ret_q    <= S_WAIT_TAIL;
							state_q  <= S_RD_WAIT;
						end
					end else if (i_q == semfp_pkg::WT_W'(semfp_pkg::NUM_WAITERS - 1)) begin
						push_q      <= 1'b1;
						push_item_q <= semfp_pkg::mk_reply(semfp_pkg::ST_NOSPACE,
							6'd0, 32'sd0);
						state_q     <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_WAIT_TAIL: begin
					// link old tail to the new waiter
					wwe_q      <= 1'b1;
					wwa_q      <= wra_q;
					wwd_q      <= we_q;
					wwd_q.next <= {1'b0, new_q};
					state_q    <= S_PI_START;
				end
				S_POST_H: begin
					se_q.head <= we_q.next;
					if (we_q.next[semfp_pkg::WT_W])
						se_q.tail <= semfp_pkg::PTR_NIL;
					wwe_q         <= 1'b1;
					wwa_q         <= h_q;
					wwd_q         <= we_q;
					wwd_q.next    <= semfp_pkg::PTR_NIL;
					wwd_q.granted <= 1'b1;
					if (owner_on && (se_q.owner_task != we_q.task_id)) begin
						push_q      <= 1'b1;
						push_item_q <= semfp_pkg::mk_event(semfp_pkg::K_CLEAR, 6'd0,
							se_q.owner_task, 8'd0);
					end
					state_q <= S_POST_G;
				end
				S_POST_G: begin
					push_q      <= 1'b1;
					push_item_q <= semfp_pkg::mk_event(semfp_pkg::K_GRANT, 6'(h_q),
						we_q.task_id, 8'd0);
					if (se_q.rt) begin
						se_q.owner_v    <= 1'b1;
						se_q.owner_task <= we_q.task_id;
					end
					state_q <= S_PI_START;
				end
				S_RT_W: begin
					gr_q     <= we_q.granted;
					tgt_q    <= we_q.sem;
					rep_q    <= semfp_pkg::mk_reply(we_q.granted ? semfp_pkg::ST_OK :
						semfp_pkg::ST_CANCEL, 6'd0, 32'sd0);
					sra_q    <= we_q.sem;
					rd_sem_q <= 1'b1;
					rd_wt_q  <= 1'b0;
					ret_q    <= S_RT_S;
					state_q  <= S_RD_WAIT;
				end
				S_RT_S: begin
					if (!gr_q && sem_act_q[tgt_q]) begin
						cur_q   <= se_q.head;
						prev_q  <= semfp_pkg::PTR_NIL;
						steps_q <= '0;
						state_q <= S_UNL_RD;
					end else begin
						state_q <= S_RT_FREE;
					end
				end
				S_UNL_RD: begin
					if (!cur_q[semfp_pkg::WT_W] &&
							(steps_q < semfp_pkg::PTR_W'(semfp_pkg::NUM_WAITERS))) begin
						wra_q    <= cur_q[semfp_pkg::WT_W-1:0];
						rd_sem_q <= 1'b0;
						rd_wt_q  <= 1'b1;
						ret_q    <= S_UNL_CHK;
						state_q  <= S_RD_WAIT;
					end else begin
						state_q <= S_RT_FREE;
					end
				end
				S_UNL_CHK: begin
					if (cur_q[semfp_pkg::WT_W-1:0] == cmd_q.waiter_slot) begin
						if (prev_q[semfp_pkg::WT_W])
							se_q.head <= we_q.next;
						else begin
							wwe_q      <= 1'b1;
							wwa_q      <= prev_q[semfp_pkg::WT_W-1:0];
							wwd_q      <= pe_q;
							wwd_q.next <= we_q.next;
						end
						if (se_q.tail == cur_q)
							se_q.tail <= prev_q;
						state_q <= S_RT_FREE;
					end else begin
						prev_q  <= cur_q;
						pe_q    <= we_q;
						cur_q   <= we_q.next;
						steps_q <= steps_q + 1'b1;
						state_q <= S_UNL_RD;
					end
				end
				S_RT_FREE: begin
					wt_act_q[cmd_q.waiter_slot] <= 1'b0;
					wwe_q <= 1'b1;
					wwa_q <= cmd_q.waiter_slot;
					wwd_q <= '{granted: 1'b0, task_id: 8'd0, prio: 8'd0,
						next: semfp_pkg::PTR_NIL, sem: '0};
					if (!gr_q && sem_act_q[tgt_q])
						state_q <= S_PI_START;
					else
						state_q <= S_DESTROY;
				end
				S_PI_START: begin
					if (!owner_on)
						state_q <= S_DESTROY;
					else begin
						cur_q   <= se_q.head;
						best_q  <= semfp_pkg::NO_PRIO;
						steps_q <= '0;
						state_q <= S_PI_RD;
					end
				end
				S_PI_RD: begin
					if (!cur_q[semfp_pkg::WT_W] &&
							(steps_q < semfp_pkg::PTR_W'(semfp_pkg::NUM_WAITERS))) begin
						wra_q    <= cur_q[semfp_pkg::WT_W-1:0];
						rd_sem_q <= 1'b0;
						rd_wt_q  <= 1'b1;
						ret_q    <= S_PI_CHK;
						state_q  <= S_RD_WAIT;
					end else begin
						push_q <= 1'b1;
						if (best_q != semfp_pkg::NO_PRIO)
							push_item_q <= semfp_pkg::mk_event(semfp_pkg::K_DONATE, 6'd0,
								se_q.owner_task, best_q);
						else
							push_item_q <= semfp_pkg::mk_event(semfp_pkg::K_CLEAR, 6'd0,
								se_q.owner_task, 8'd0);
						state_q <= S_DESTROY;
					end
				end
				S_PI_CHK: begin
					if (we_q.prio < best_q)
						best_q <= we_q.prio;
					cur_q   <= we_q.next;
					steps_q <= steps_q + 1'b1;
					state_q <= S_PI_RD;
				end
				S_DESTROY: begin
					if (sem_act_q[tgt_q] && se_q.head[semfp_pkg::WT_W] &&
							(se_q.refs == 16'd0)) begin
						if (owner_on) begin
							push_q      <= 1'b1;
							push_item_q <= semfp_pkg::mk_event(semfp_pkg::K_CLEAR, 6'd0,
								se_q.owner_task, 8'd0);
						end
						sem_act_q[tgt_q] <= 1'b0;
						se_q.owner_v     <= 1'b0;
						se_q.owner_task  <= 8'd0;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					swe_q       <= 1'b1;
					swa_q       <= tgt_q;
					swd_q       <= se_q;
					push_q      <= 1'b1;
					push_item_q <= rep_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/semaphore_engine_fifo_pi_unit.sv]
// ----------------------------------------------------------------------------
// semaphore_engine_fifo_pi_unit
// Counting semaphore pool with FIFO wait queues and priority inheritance.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_* stream, one beat per command. Each command
//   yields zero to three event beats (grant, donate, clear) and then one
//   reply beat with m_tlast high; m_tuser carries the kind.
//   Create and a wait that queues scan the slot bitmaps one slot per
//   cycle, over up to 64 slots. Priority inheritance and queue unlink
//   walk the waiter list one hop at a time (read, wait, latch, check)
//   through the single read port of the waiter RAM, for up to 64 hops;
//   one command is in work at a time.
//   Results go through an 8-beat queue, so the next command is taken while
//   earlier results still wait, as long as four beats of room remain.
//   Reset clears the active bitmaps of semaphores and waiters; the RAM
//   contents need no clearing, no pass after reset.
//   A stalled m_tready only fills the result queue; s_tready drops once
//   the queue cannot hold a full command's results.
// ----------------------------------------------------------------------------
module semaphore_engine_fifo_pi_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sem_slot[5:0] waiter_slot[11:6] task_id[19:12] task_prio[27:20]
	// init_value[58:28] rt_mode[59], zero above
	input  logic [63:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0] slot_out[8:3] task_out[16:9] prio_out[24:17]
	// count_out[56:25], zero above
	output logic [63:0] m_tdata,
	// kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	semfp_pkg::cmd_t      cmd;
	semfp_pkg::res_t      push_item, out_item;
	semfp_pkg::smem_req_t sreq;
	semfp_pkg::wmem_req_t wreq;
	semfp_pkg::sem_ent_t  srdata;
	semfp_pkg::wt_ent_t   wrdata;
	logic                 push, room;

	// unpack the command beat
	assign cmd.opcode      = s_tuser;
	assign cmd.sem_slot    = s_tdata[5:0];
	assign cmd.waiter_slot = s_tdata[11:6];
	assign cmd.task_id     = s_tdata[19:12];
	assign cmd.task_prio   = s_tdata[27:20];
	assign cmd.init_value  = s_tdata[58:28];
	assign cmd.rt_mode     = s_tdata[59];

	semfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (cmd),
		.room      (room),
		.push      (push),
		.push_item (push_item),
		.sreq      (sreq),
		.srdata    (srdata),
		.wreq      (wreq),
		.wrdata    (wrdata)
	);

	// semaphore table: count, mode, refs, owner, queue head/tail
	semfp_ram #(
		.WIDTH ($bits(semfp_pkg::sem_ent_t)),
		.DEPTH (semfp_pkg::NUM_SEMS)
	) u_sem_ram (
		.clk   (clk),
		.we    (sreq.we),
		.waddr (sreq.waddr),
		.wdata (sreq.wdata),
		.raddr (sreq.raddr),
		.rdata (srdata)
	);

	// waiter table: granted, task, prio, link, owning semaphore
	semfp_ram #(
		.WIDTH ($bits(semfp_pkg::wt_ent_t)),
		.DEPTH (semfp_pkg::NUM_WAITERS)
	) u_wt_ram (
		.clk   (clk),
		.we    (wreq.we),
		.waddr (wreq.waddr),
		.wdata (wreq.wdata),
		.raddr (wreq.raddr),
		.rdata (wrdata)
	);

	semfp_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	// pack the result beat
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;
	assign m_tdata = {7'd0, out_item.count_out, out_item.prio_out, out_item.task_out,
		out_item.slot_out, out_item.status};

endmodule

[hw/rtl/semfp_checker.sv]
// ----------------------------------------------------------------------------
// semfp_checker
// Port-level checks of the semaphore unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "semaphore_engine_fifo_pi_unit_assert.svh"

module semfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result beat stays offered
	`SEFP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// events never close a command
	`SEFP_ASSERT_NOW(a_event_not_last, clk, arst_n,
		m_tvalid && (m_tuser != semfp_pkg::K_REPLY), !m_tlast)
	// events carry no status and no count
	`SEFP_ASSERT_NOW(a_event_clean, clk, arst_n,
		m_tvalid && (m_tuser != semfp_pkg::K_REPLY),
		(m_tdata[2:0] == semfp_pkg::ST_OK) && (m_tdata[56:25] == 32'd0))
	// only getvalue replies carry a count: status must be ok then
	`SEFP_ASSERT_NOW(a_count_ok, clk, arst_n,
		m_tvalid && (m_tdata[56:25] != 32'd0), m_tlast && (m_tdata[2:0] == semfp_pkg::ST_OK))

endmodule

bind semaphore_engine_fifo_pi_unit semfp_checker u_semfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
